/* hdl/pbt_pkg.sv */
// Shared types and constants for the projected barycentric test block.
// No dependencies; imported by pbt_mul and projected_barycentric_test_top.
`timescale 1ns / 1ps

package pbt_pkg;

  // Configuration register indexes
  localparam logic REG_INSIDE_TOL = 1'b0;
  localparam logic REG_DIST_LIMIT = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam int TOL_W      = 25;
  localparam int LIM_W      = 31;

  localparam logic [TOL_W-1:0] TOL_RESET   = 25'd167772;   // about 0.01 in Q8.24
  localparam logic [LIM_W-1:0] LIMIT_RESET = 31'd65536;    // 1.0 in Q16.16

  localparam int COORD_WIDTH_DEF = 32;
  localparam int LIMB_WIDTH_DEF  = 34;   // partial product limb width
  localparam int MUL_LAT         = 4;    // pbt_mul register stages
  localparam int QB              = 32;   // quotient / root bits
  localparam int WFRAC           = 24;   // weight fraction bits

  localparam logic signed [33:0] WEIGHT_ONE = 34'sd16777216;
  localparam logic signed [31:0] SAT_MAX    = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN    = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] vertex_a_x;
    logic signed [31:0] vertex_a_y;
    logic signed [31:0] vertex_a_z;
    logic signed [31:0] vertex_b_x;
    logic signed [31:0] vertex_b_y;
    logic signed [31:0] vertex_b_z;
    logic signed [31:0] vertex_c_x;
    logic signed [31:0] vertex_c_y;
    logic signed [31:0] vertex_c_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] weight_alpha;
    logic signed [31:0] weight_beta;
    logic signed [31:0] weight_gamma;
    logic signed [31:0] plane_distance;
    logic               inside_res;
    logic               inside_and_near;
    logic               degenerate;
  } out_item_t;

endpackage

/* hdl/pbt_mul.sv */
// Pipelined signed multiplier built from LW x LW limb products.
// Uses pbt_pkg; fully pipelined, advances every cycle.
`timescale 1ns / 1ps

module pbt_mul
  import pbt_pkg::*;
#(
  parameter int AW = 34,
  parameter int BW = 34,
  parameter int LW = LIMB_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NA = (AW + LW - 1) / LW;
  localparam int NB = (BW + LW - 1) / LW;
  localparam int PW = AW + BW;

  logic [AW-1:0]      abs_a;
  logic [BW-1:0]      abs_b;
  logic [NA*LW-1:0]   ma;
  logic [NB*LW-1:0]   mb;
  logic               sgn0, sgn1, sgn2;
  logic [2*LW-1:0]    pp [NA][NB];
  logic [PW-1:0]      row_next [NA];
  logic [PW-1:0]      row [NA];
  logic [PW-1:0]      tot;

  assign abs_a = a[AW-1] ? (~a + 1'b1) : a;
  assign abs_b = b[BW-1] ? (~b + 1'b1) : b;

  // stage 1: magnitudes
  always_ff @(posedge clk) begin
    sgn0 <= a[AW-1] ^ b[BW-1];
    ma   <= (NA*LW)'(abs_a);
    mb   <= (NB*LW)'(abs_b);
  end

  // stage 2: limb products
  for (genvar i = 0; i < NA; i++) begin : g_row
    for (genvar j = 0; j < NB; j++) begin : g_col
      always_ff @(posedge clk) begin
        pp[i][j] <= ma[i*LW +: LW] * mb[j*LW +: LW];
      end
    end
  end

  // stage 3: row sums
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) << (j*LW));
      end
    end
  end

  always_comb begin
    tot = '0;
    for (int i = 0; i < NA; i++) begin
      tot = tot + (row[i] << (i*LW));
    end
  end

  always_ff @(posedge clk) begin
    sgn1 <= sgn0;
    sgn2 <= sgn1;
    row  <= row_next;
    // stage 4: total and sign
    p    <= sgn2 ? (~tot + 1'b1) : tot;
  end

endmodule

/* hdl/projected_barycentric_test_top.sv */
// Top level of the projected barycentric point-in-triangle test.
// Uses pbt_pkg and pbt_mul.
`timescale 1ns / 1ps

// One query (point plus triangle) is taken per transfer, at any clock edge where
// start is high; busy stays low, so a new query may follow every cycle. The
// pipe is 50 register stages deep (2*MUL_LAT + 42): the result sits on result
// with done high for exactly one cycle, once the query has passed every stage.
// The stages include two multiplier passes for the cross and dot products,
// the squaring of n.w, then 32 pipelined restoring steps that produce the
// weight quotients and the plane-distance root one bit per stage. There is no
// backpressure: the receiver must take every result in its done cycle.
// Configuration writes take effect at once and should be made only while no
// query is in flight.
module projected_barycentric_test_top
  import pbt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int LIMB_WIDTH  = LIMB_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output out_item_t             result
);

  // Coordinates use at most 32 bits; everything below is sized from that.
  localparam int CWE  = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam int DW   = CWE + 1;            // edge / offset vectors
  localparam int XW   = 2 * DW;             // cross product components
  localparam int DTW  = 2 * XW + 2;         // dot products of cross vectors
  localparam int NDW  = XW + DW + 2;        // n . w
  localparam int DENW = 2 * XW;             // n . n, nonnegative
  localparam int NUMW = DENW + 4;           // weight numerators
  localparam int WDW  = DENW + QB + 1;      // divider remainder
  localparam int TW   = DENW + QB;          // q * den in root search
  localparam int SQW  = (2 * NDW > DENW + 2 * QB + 2) ? 2 * NDW : DENW + 2 * QB + 2;
  localparam int LAST = 2 * MUL_LAT + QB + 10;

  logic [LAST:1] vld;
  logic          acc;

  logic [TOL_W-1:0] tol;
  logic [LIM_W-1:0] lim;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
      lim <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INSIDE_TOL: tol <= cfg_data[TOL_W-1:0];
        REG_DIST_LIMIT: lim <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits walk with the data; nothing ever stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAST-1:1], acc};
    end
  end

  // ---------------------------------------------------- stage 1: u, v, w
  logic signed [31:0]   pin [3], ain [3], bin [3], cin [3];
  logic signed [DW-1:0] u1 [3], v1 [3], w1 [3];

  always_comb begin
    pin = '{item.point_x, item.point_y, item.point_z};
    ain = '{item.vertex_a_x, item.vertex_a_y, item.vertex_a_z};
    bin = '{item.vertex_b_x, item.vertex_b_y, item.vertex_b_z};
    cin = '{item.vertex_c_x, item.vertex_c_y, item.vertex_c_z};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u1[i] <= DW'($signed(bin[i][CWE-1:0])) - DW'($signed(ain[i][CWE-1:0]));
      v1[i] <= DW'($signed(cin[i][CWE-1:0])) - DW'($signed(ain[i][CWE-1:0]));
      w1[i] <= DW'($signed(pin[i][CWE-1:0])) - DW'($signed(ain[i][CWE-1:0]));
    end
  end

  // ---------------------------------- stages 2-6: n = u x v, u x w, w x v
  // pair 0: (u, v), pair 1: (u, w), pair 2: (w, v)
  logic signed [DW-1:0]   xa [3][3], xb [3][3];
  logic signed [2*DW-1:0] pp_pos [3][3], pp_neg [3][3];
  logic signed [XW-1:0]   xr [3][3];
  logic signed [DW-1:0]   w_dl [5][3];

  always_comb begin
    xa[0] = u1; xb[0] = v1;
    xa[1] = u1; xb[1] = w1;
    xa[2] = w1; xb[2] = v1;
  end

  for (genvar p = 0; p < 3; p++) begin : g_xp
    for (genvar c = 0; c < 3; c++) begin : g_xc
      pbt_mul #(.AW(DW), .BW(DW), .LW(LIMB_WIDTH)) u_pos (
        .clk (clk),
        .a   (xa[p][(c+1)%3]),
        .b   (xb[p][(c+2)%3]),
        .p   (pp_pos[p][c])
      );
      pbt_mul #(.AW(DW), .BW(DW), .LW(LIMB_WIDTH)) u_neg (
        .clk (clk),
        .a   (xa[p][(c+2)%3]),
        .b   (xb[p][(c+1)%3]),
        .p   (pp_neg[p][c])
      );
      always_ff @(posedge clk) begin
        xr[p][c] <= pp_pos[p][c] - pp_neg[p][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    w_dl[0] <= w1;
    for (int s = 1; s < 5; s++) begin
      w_dl[s] <= w_dl[s-1];
    end
  end

  // -------------------------------------------- stages 7-11: dot products
  logic signed [2*XW-1:0]  dn_p [3], dg_p [3], db_p [3];
  logic signed [XW+DW-1:0] dd_p [3];
  logic signed [DTW-1:0]   den11, g11, b11;
  logic signed [NDW-1:0]   nd11;

  for (genvar c = 0; c < 3; c++) begin : g_dot
    pbt_mul #(.AW(XW), .BW(XW), .LW(LIMB_WIDTH)) u_dn (
      .clk (clk), .a (xr[0][c]), .b (xr[0][c]), .p (dn_p[c])
    );
    pbt_mul #(.AW(XW), .BW(XW), .LW(LIMB_WIDTH)) u_dg (
      .clk (clk), .a (xr[1][c]), .b (xr[0][c]), .p (dg_p[c])
    );
    pbt_mul #(.AW(XW), .BW(XW), .LW(LIMB_WIDTH)) u_db (
      .clk (clk), .a (xr[2][c]), .b (xr[0][c]), .p (db_p[c])
    );
    pbt_mul #(.AW(XW), .BW(DW), .LW(LIMB_WIDTH)) u_dd (
      .clk (clk), .a (xr[0][c]), .b (w_dl[4][c]), .p (dd_p[c])
    );
  end

  always_ff @(posedge clk) begin
    den11 <= DTW'(dn_p[0]) + DTW'(dn_p[1]) + DTW'(dn_p[2]);
    g11   <= DTW'(dg_p[0]) + DTW'(dg_p[1]) + DTW'(dg_p[2]);
    b11   <= DTW'(db_p[0]) + DTW'(db_p[1]) + DTW'(db_p[2]);
    nd11  <= NDW'(dd_p[0]) + NDW'(dd_p[1]) + NDW'(dd_p[2]);
  end

  // ------------------- stages 12-15: (n.w)^2, numerators wait alongside
  logic signed [2*NDW-1:0] sq15;
  logic signed [DTW-1:0]   den_dl [MUL_LAT], g_dl [MUL_LAT], b_dl [MUL_LAT];
  logic                    nneg_dl [MUL_LAT];

  pbt_mul #(.AW(NDW), .BW(NDW), .LW(LIMB_WIDTH)) u_sq (
    .clk (clk), .a (nd11), .b (nd11), .p (sq15)
  );

  always_ff @(posedge clk) begin
    den_dl[0]  <= den11;
    g_dl[0]    <= g11;
    b_dl[0]    <= b11;
    nneg_dl[0] <= nd11[NDW-1];
    for (int s = 1; s < MUL_LAT; s++) begin
      den_dl[s]  <= den_dl[s-1];
      g_dl[s]    <= g_dl[s-1];
      b_dl[s]    <= b_dl[s-1];
      nneg_dl[s] <= nneg_dl[s-1];
    end
  end

  // ------------------------------------------- stage 16: numerators
  logic signed [NUMW-1:0] num16 [3];
  logic [DENW-1:0]        den16;
  logic [2*NDW-1:0]       sq16;
  logic                   nneg16, degen16;

  always_ff @(posedge clk) begin
    num16[0] <= NUMW'(den_dl[MUL_LAT-1]) - NUMW'(b_dl[MUL_LAT-1])
                - NUMW'(g_dl[MUL_LAT-1]);
    num16[1] <= NUMW'(b_dl[MUL_LAT-1]);
    num16[2] <= NUMW'(g_dl[MUL_LAT-1]);
    den16    <= den_dl[MUL_LAT-1][DENW-1:0];
    degen16  <= (den_dl[MUL_LAT-1] == '0);
    nneg16   <= nneg_dl[MUL_LAT-1];
    sq16     <= sq15;
  end

  // ------------------------- stages 17-49: restoring divide and root
  // Index 0 holds the initial state; index s has resolved bit QB-s.
  // Divide: q = floor(|num| * 2^24 / den), flagged when it reaches 2^32.
  // Root:   largest q with q^2 * den <= (n.w)^2, tracked as
  //         remainder sr = (n.w)^2 - q^2*den and st = q*den.
  logic [WDW-1:0]  dr   [QB+1][3];
  logic [QB-1:0]   dq   [QB+1][3];
  logic            dneg [QB+1][3];
  logic            dov  [QB+1][3];
  logic [DENW-1:0] den_it [QB+1];
  logic [SQW-1:0]  sr   [QB+1];
  logic [TW-1:0]   st   [QB+1];
  logic [QB-1:0]   rq   [QB+1];
  logic            nneg_it  [QB+1];
  logic            degen_it [QB+1];
  logic [NUMW-1:0] mag16 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag16[i] = num16[i][NUMW-1] ? NUMW'(-num16[i]) : NUMW'(num16[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dr[0][i]   <= WDW'(mag16[i]) << WFRAC;
      dov[0][i]  <= (WDW'(mag16[i]) << WFRAC) >= (WDW'(den16) << QB);
      dq[0][i]   <= '0;
      dneg[0][i] <= num16[i][NUMW-1];
    end
    den_it[0]   <= den16;
    sr[0]       <= SQW'(sq16);
    st[0]       <= '0;
    rq[0]       <= '0;
    nneg_it[0]  <= nneg16;
    degen_it[0] <= degen16;
  end

  for (genvar s = 1; s <= QB; s++) begin : g_it
    localparam int K = QB - s;
    logic [WDW-1:0] dtrial;
    logic [SQW-1:0] rtrial;
    logic           rfit;

    assign dtrial = WDW'(den_it[s-1]) << K;
    assign rtrial = (SQW'(st[s-1]) << (K + 1)) + (SQW'(den_it[s-1]) << (2 * K));
    assign rfit   = (rtrial <= sr[s-1]);

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        dneg[s][i] <= dneg[s-1][i];
        dov[s][i]  <= dov[s-1][i];
        if (dr[s-1][i] >= dtrial) begin
          dr[s][i] <= dr[s-1][i] - dtrial;
          dq[s][i] <= dq[s-1][i] | (QB'(1) << K);
        end else begin
          dr[s][i] <= dr[s-1][i];
          dq[s][i] <= dq[s-1][i];
        end
      end
      if (rfit) begin
        sr[s] <= sr[s-1] - rtrial;
        st[s] <= st[s-1] + (TW'(den_it[s-1]) << K);
        rq[s] <= rq[s-1] | (QB'(1) << K);
      end else begin
        sr[s] <= sr[s-1];
        st[s] <= st[s-1];
        rq[s] <= rq[s-1];
      end
      den_it[s]   <= den_it[s-1];
      nneg_it[s]  <= nneg_it[s-1];
      degen_it[s] <= degen_it[s-1];
    end
  end

  // -------------------------- stage 50: saturate, flags, result register
  out_item_t          res_next;
  logic signed [31:0] wt [3];
  logic signed [31:0] dist_sat;
  logic signed [33:0] wt_ext, tol_ext;
  logic [QB-1:0]      q;
  logic               ins;

  always_comb begin
    ins = 1'b1;
    tol_ext = 34'(tol);
    for (int i = 0; i < 3; i++) begin
      q = dq[QB][i];
      if (dneg[QB][i]) begin
        wt[i] = (dov[QB][i] || (q[QB-1] && (|q[QB-2:0]))) ? SAT_MIN : -$signed(q);
      end else begin
        wt[i] = (dov[QB][i] || q[QB-1]) ? SAT_MAX : $signed(q);
      end
      wt_ext = 34'(wt[i]);
      if (wt_ext < -tol_ext || wt_ext > WEIGHT_ONE + tol_ext) begin
        ins = 1'b0;
      end
    end
    // root saturates to SAT_MAX or SAT_MIN once bit 31 is set
    q = rq[QB];
    if (nneg_it[QB]) begin
      dist_sat = q[QB-1] ? SAT_MIN : -$signed(q);
    end else begin
      dist_sat = q[QB-1] ? SAT_MAX : $signed(q);
    end

    res_next.weight_alpha    = wt[0];
    res_next.weight_beta     = wt[1];
    res_next.weight_gamma    = wt[2];
    res_next.plane_distance  = dist_sat;
    res_next.inside_res      = ins;
    res_next.inside_and_near = ins && (33'(dist_sat) < $signed({2'b00, lim}));
    res_next.degenerate      = 1'b0;
    if (degen_it[QB]) begin
      res_next = '0;
      res_next.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  assign done = vld[LAST];

  // ---------------------------------------------------------- checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##LAST done)
    else $error("query transfer did not produce a result on time");

  a_near_needs_inside: assert property (@(posedge clk) disable iff (rst)
    done && result.inside_and_near |-> result.inside_res)
    else $error("inside_and_near without inside_res");

  a_degen_flags: assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |-> !result.inside_res && !result.inside_and_near)
    else $error("degenerate triangle reported inside");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |-> result.weight_alpha == '0 &&
      result.weight_beta == '0 && result.weight_gamma == '0 &&
      result.plane_distance == '0)
    else $error("degenerate triangle with nonzero weights or distance");

endmodule
